// ----- hw/rtl/wts_pkg.sv -----
// Shared types, command codes and character helpers for the word sorter.
// No dependencies; the top level and the testbench import this package.
`timescale 1ns / 1ps

package wts_pkg;

   // Command codes carried in the func field of an input item
   typedef enum logic [1:0] {
      FUNC_TEXT = 2'd0,
      FUNC_END  = 2'd1,
      FUNC_PULL = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;

   // Sequencer states, one-hot
   typedef enum logic [11:0] {
      ST_LOAD    = 12'b0000_0000_0001,
      ST_OUT     = 12'b0000_0000_0010,
      ST_SORT_I  = 12'b0000_0000_0100,
      ST_ORD_RD  = 12'b0000_0000_1000,
      ST_LEN_RD  = 12'b0000_0001_0000,
      ST_CHR_CMP = 12'b0000_0010_0000,
      ST_SHIFT   = 12'b0000_0100_0000,
      ST_PLACE   = 12'b0000_1000_0000,
      ST_P_ORD   = 12'b0001_0000_0000,
      ST_P_LEN   = 12'b0010_0000_0000,
      ST_P_CHR   = 12'b0100_0000_0000,
      ST_SPARE   = 12'b1000_0000_0000
   } state_type;

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE) || (c == CHAR_TAB);
   endfunction

   // Fold ASCII upper case letters to lower case
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'd65:8'd90]}) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/wts_if.sv -----
// Valid/ready channel interfaces for the word sorter's request and response items.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface wts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] text_byte;

   modport source (output valid, output func, output text_byte, input ready);
   modport sink (input valid, input func, input text_byte, output ready);
endinterface

interface wts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [8:0] word_count;
   logic       last_byte;
   logic       out_empty;

   modport source (output valid, output out_byte, output word_count, output last_byte,
                   output out_empty, input ready);
   modport sink (input valid, input out_byte, input word_count, input last_byte,
                 input out_empty, output ready);
endinterface

// ----- hw/rtl/wts_ram.sv -----
// Synchronous RAM with one write port and two registered read ports.
// No package dependencies; instantiated by the top level for each store.
`timescale 1ns / 1ps

module wts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr_a,
   output logic [WIDTH-1:0] rdata_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read two through registered outputs
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// ----- hw/rtl/word_tokenize_and_sort_core.sv -----
// Word sorter top level: tokenizing loader, insertion-sort sequencer, output reader.
// Depends on wts_pkg, wts_if and wts_ram.
//
// Usage: items arrive on req_ch (func, text_byte) and results leave on rsp_ch.
// Text items (func 0) are taken one per cycle, unless a result waits, and
// give no result. An end item (func 1) closes the last word, sorts the stored
// words and returns the count. Pull items (func 2) return the sorted text one
// byte per item, a newline after each word and last_byte on the final newline;
// out_empty when nothing is left. A pull reads in turn through the order,
// length and character memories. The end item sorts the stored words by
// insertion, with one character compare per cycle on the character memory.
// A second end item, or a pull that finds nothing, answers with no memory read.
// The result waits in an output register; while it is not taken, no new item
// is accepted. Reset clears the counters and returns to loading; the memories
// hold no defined contents until written and need no clearing pass.
`timescale 1ns / 1ps

module word_tokenize_and_sort_core import wts_pkg::*; #(
   parameter int NUM_WORDS = 256,
   parameter int WORD_LEN  = 16
) (
   input  logic      clock,
   input  logic      reset,
   wts_req_if.sink   req_ch,
   wts_rsp_if.source rsp_ch
);

   localparam int WI_W  = $clog2(NUM_WORDS);
   localparam int CNT_W = $clog2(NUM_WORDS + 1);
   localparam int CH_W  = $clog2(WORD_LEN);
   localparam int SA_W  = WI_W + CH_W;
   localparam int STORE_DEPTH = NUM_WORDS * (2 ** CH_W);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [CH_W-1:0]  cpos_ff, cpos_in;
   logic             skip_ff, skip_in;
   logic [CNT_W-1:0] rword_ff, rword_in;
   logic [CH_W-1:0]  rchar_ff, rchar_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [WI_W-1:0]  j_ff, j_in;
   logic [WI_W-1:0]  cur_ff, cur_in;
   logic [WI_W-1:0]  prev_ff, prev_in;
   logic [CH_W-1:0]  la_ff, la_in;
   logic [CH_W-1:0]  lb_ff, lb_in;
   logic [CH_W-1:0]  k_ff, k_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [8:0]       count_ff, count_in;
   logic             last_ff, last_in;
   logic             empty_ff, empty_in;

   // Memory ports
   logic             str_we;
   logic [SA_W-1:0]  str_wa, str_ra, str_rb;
   logic [7:0]       str_wd, str_da, str_db;
   logic             len_we;
   logic [WI_W-1:0]  len_wa, len_ra, len_rb;
   logic [CH_W-1:0]  len_wd, len_da, len_db;
   logic             ord_we;
   logic [WI_W-1:0]  ord_wa, ord_ra;
   logic [WI_W-1:0]  ord_wd, ord_da;

   logic             accept;
   logic             idle;
   logic [CH_W-1:0]  min_len;
   logic [7:0]       ca, cb;

   wts_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .we(str_we), .waddr(str_wa), .wdata(str_wd),
      .raddr_a(str_ra), .rdata_a(str_da), .raddr_b(str_rb), .rdata_b(str_db)
   );

   wts_ram #(.WIDTH(CH_W), .DEPTH(NUM_WORDS)) u_length (
      .clock(clock), .we(len_we), .waddr(len_wa), .wdata(len_wd),
      .raddr_a(len_ra), .rdata_a(len_da), .raddr_b(len_rb), .rdata_b(len_db)
   );

   wts_ram #(.WIDTH(WI_W), .DEPTH(NUM_WORDS)) u_order (
      .clock(clock), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
      .raddr_a(ord_ra), .rdata_a(ord_da), .raddr_b('0), .rdata_b()
   );

   assign idle   = (state_ff == ST_LOAD) || (state_ff == ST_OUT);
   assign req_ch.ready = idle && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;

   assign min_len = (la_ff < lb_ff) ? la_ff : lb_ff;
   assign ca = fold_char(str_da);
   assign cb = fold_char(str_db);

   // Sequence loading, sorting and reading
   always_comb begin
      state_in   = state_ff;
      stored_in  = stored_ff;
      cpos_in    = cpos_ff;
      skip_in    = skip_ff;
      rword_in   = rword_ff;
      rchar_in   = rchar_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      la_in      = la_ff;
      lb_in      = lb_ff;
      k_in       = k_ff;
      out_byte_in = out_byte_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      empty_in   = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      str_we = 1'b0;
      str_wa = {stored_ff[WI_W-1:0], cpos_ff};
      str_wd = req_ch.text_byte;
      str_ra = '0;
      str_rb = '0;
      len_we = 1'b0;
      len_wa = stored_ff[WI_W-1:0];
      len_wd = cpos_ff;
      len_ra = '0;
      len_rb = '0;
      ord_we = 1'b0;
      ord_wa = j_ff;
      ord_wd = cur_ff;
      ord_ra = '0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               case (func_type'(req_ch.func))
                  FUNC_TEXT: begin
                     if (stored_ff < CNT_W'(NUM_WORDS)) begin
                        if (is_separator(req_ch.text_byte)) begin
                           if (skip_ff) begin
                              skip_in = 1'b0;
                           end else begin
                              if (cpos_ff != '0) begin
                                 len_we    = 1'b1;
                                 stored_in = stored_ff + 1'b1;
                              end
                              cpos_in = '0;
                           end
                        end else if (!skip_ff) begin
                           if (cpos_ff == CH_W'(WORD_LEN - 1)) begin
                              // Cut the word and drop its tail
                              len_we    = 1'b1;
                              stored_in = stored_ff + 1'b1;
                              cpos_in   = '0;
                              skip_in   = 1'b1;
                           end else begin
                              str_we  = 1'b1;
                              cpos_in = cpos_ff + 1'b1;
                           end
                        end
                     end
                  end
                  FUNC_END: begin
                     if (cpos_ff != '0 && stored_ff < CNT_W'(NUM_WORDS)) begin
                        len_we    = 1'b1;
                        stored_in = stored_ff + 1'b1;
                     end
                     cpos_in  = '0;
                     skip_in  = 1'b0;
                     i_in     = '0;
                     state_in = ST_SORT_I;
                  end
                  FUNC_PULL: begin
                     rsp_valid_in = 1'b1;
                     out_byte_in  = '0;
                     count_in     = '0;
                     last_in      = 1'b0;
                     empty_in     = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (accept) begin
               case (func_type'(req_ch.func))
                  FUNC_END: begin
                     rword_in     = '0;
                     rchar_in     = '0;
                     rsp_valid_in = 1'b1;
                     out_byte_in  = '0;
                     count_in     = 9'(stored_ff);
                     last_in      = 1'b0;
                     empty_in     = 1'b0;
                  end
                  FUNC_PULL: begin
                     if (rword_ff >= stored_ff) begin
                        rsp_valid_in = 1'b1;
                        out_byte_in  = '0;
                        count_in     = '0;
                        last_in      = 1'b0;
                        empty_in     = 1'b1;
                     end else begin
                        ord_ra   = rword_ff[WI_W-1:0];
                        state_in = ST_P_ORD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Start the insertion of word i
         ST_SORT_I: begin
            if (i_ff >= stored_ff) begin
               rword_in     = '0;
               rchar_in     = '0;
               rsp_valid_in = 1'b1;
               out_byte_in  = '0;
               count_in     = 9'(stored_ff);
               last_in      = 1'b0;
               empty_in     = 1'b0;
               state_in     = ST_OUT;
            end else begin
               cur_in = i_ff[WI_W-1:0];
               j_in   = i_ff[WI_W-1:0];
               if (i_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  ord_ra   = WI_W'(i_ff - 1'b1);
                  state_in = ST_ORD_RD;
               end
            end
         end
         // Fetch the lengths of the left neighbor and the inserted word
         ST_ORD_RD: begin
            prev_in  = ord_da;
            len_ra   = ord_da;
            len_rb   = cur_ff;
            state_in = ST_LEN_RD;
         end
         ST_LEN_RD: begin
            la_in    = len_da;
            lb_in    = len_db;
            k_in     = '0;
            str_ra   = {prev_ff, {CH_W{1'b0}}};
            str_rb   = {cur_ff, {CH_W{1'b0}}};
            state_in = ST_CHR_CMP;
         end
         // Compare one folded character a cycle
         ST_CHR_CMP: begin
            if (ca != cb) begin
               state_in = (ca > cb) ? ST_SHIFT : ST_PLACE;
            end else if ({1'b0, k_ff} + 1'b1 >= {1'b0, min_len}) begin
               state_in = (la_ff > lb_ff) ? ST_SHIFT : ST_PLACE;
            end else begin
               k_in   = k_ff + 1'b1;
               str_ra = {prev_ff, k_ff + 1'b1};
               str_rb = {cur_ff, k_ff + 1'b1};
            end
         end
         ST_SHIFT: begin
            ord_we = 1'b1;
            ord_wa = j_ff;
            ord_wd = prev_ff;
            j_in   = j_ff - 1'b1;
            if (j_ff == WI_W'(1)) begin
               state_in = ST_PLACE;
            end else begin
               ord_ra   = j_ff - WI_W'(2);
               state_in = ST_ORD_RD;
            end
         end
         ST_PLACE: begin
            ord_we   = 1'b1;
            ord_wa   = j_ff;
            ord_wd   = cur_ff;
            i_in     = i_ff + 1'b1;
            state_in = ST_SORT_I;
         end
         // Pull: order entry, then length and character
         ST_P_ORD: begin
            prev_in  = ord_da;
            len_ra   = ord_da;
            state_in = ST_P_LEN;
         end
         ST_P_LEN: begin
            la_in    = len_da;
            str_ra   = {prev_ff, rchar_ff};
            state_in = ST_P_CHR;
         end
         ST_P_CHR: begin
            rsp_valid_in = 1'b1;
            count_in     = '0;
            empty_in     = 1'b0;
            last_in      = 1'b0;
            if (rchar_ff < la_ff) begin
               out_byte_in = str_da;
               rchar_in    = rchar_ff + 1'b1;
            end else begin
               out_byte_in = CHAR_NEWLINE;
               rchar_in    = '0;
               rword_in    = rword_ff + 1'b1;
               last_in     = (rword_ff + 1'b1 >= stored_ff);
            end
            state_in = ST_OUT;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         stored_ff    <= '0;
         cpos_ff      <= '0;
         skip_ff      <= 1'b0;
         rword_ff     <= '0;
         rchar_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         cpos_ff      <= cpos_in;
         skip_ff      <= skip_in;
         rword_ff     <= rword_in;
         rchar_ff     <= rchar_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      k_ff        <= k_in;
      out_byte_ff <= out_byte_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.word_count = count_ff;
   assign rsp_ch.last_byte  = last_ff;
   assign rsp_ch.out_empty  = empty_ff;

   // Stored count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(NUM_WORDS))
      else $error("stored word count above capacity");

   // Read pointer stays within the stored words
   assert property (@(posedge clock) disable iff (reset)
      rword_ff <= stored_ff)
      else $error("read pointer past stored words");

   // End of the sort posts the count and enters the output phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT_I && i_ff >= stored_ff) |=> (rsp_valid_ff && state_ff == ST_OUT))
      else $error("sort finished without a count item");

   // Insertion point never moves past the inserted word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT || state_ff == ST_PLACE) |-> ({1'b0, j_ff} <= i_ff))
      else $error("insertion index beyond current word");

   // A pull that reads memory always ends in a result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_LEN) |=> (state_ff == ST_P_CHR) ##1 rsp_valid_ff)
      else $error("pull did not produce an item");

endmodule

// ----- tb/tb_word_tokenize_and_sort_core.sv -----
// Self-checking testbench for word_tokenize_and_sort_core: random words in, sorted bytes out.
// Depends on wts_pkg and the wts_req_if / wts_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_word_tokenize_and_sort_core;
   import wts_pkg::*;

   localparam int NUM_WORDS  = 256;
   localparam int WORD_LEN   = 16;
   localparam int IDLE_LIMIT = 2000000;

   typedef struct {
      logic [7:0] out_byte;
      logic [8:0] word_count;
      logic       last_byte;
      logic       out_empty;
   } sorted_rsp_t;

   // Tracks the sorter's word store and output pointer, holds expected items
   class word_sort_scoreboard;
      logic [7:0]  chars[NUM_WORDS][WORD_LEN];
      int          lens[NUM_WORDS];
      int          order[NUM_WORDS];
      int          nwords, cpos, rd_word, rd_char;
      bit          skipping, sending;
      sorted_rsp_t expected_rsp[$];
      int          errors;

      function logic [7:0] fold(logic [7:0] c);
         return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
      endfunction

      function bit sorts_after(int a, int b);
         int n;
         n = (lens[a] < lens[b]) ? lens[a] : lens[b];
         for (int i = 0; i < n; i++) begin
            if (fold(chars[a][i]) != fold(chars[b][i]))
               return fold(chars[a][i]) > fold(chars[b][i]);
         end
         return lens[a] > lens[b];
      endfunction

      function void close_word();
         if (cpos != 0 && nwords < NUM_WORDS) begin
            lens[nwords] = cpos;
            nwords++;
         end
         cpos = 0;
      endfunction

      // Stable insertion sort over word numbers
      function void sort_words();
         int cur, j;
         for (int i = 0; i < nwords; i++) order[i] = i;
         for (int i = 1; i < nwords; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && sorts_after(order[j-1], cur)) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = cur;
         end
      endfunction

      function int output_bytes();
         int n;
         n = nwords;
         for (int i = 0; i < nwords; i++) n += lens[i];
         return n;
      endfunction

      function void note_item(logic [1:0] f, logic [7:0] c);
         sorted_rsp_t r;
         int w;
         r = '{8'd0, 9'd0, 1'b0, 1'b0};
         case (f)
            FUNC_TEXT: begin
               if (sending || nwords >= NUM_WORDS) return;
               if (is_sep(c)) begin
                  if (skipping) skipping = 0;
                  else close_word();
               end else if (!skipping) begin
                  if (cpos >= WORD_LEN - 1) begin
                     close_word();
                     skipping = 1;
                  end else begin
                     chars[nwords][cpos] = c;
                     cpos++;
                  end
               end
               return;
            end
            FUNC_END: begin
               if (!sending) begin
                  close_word();
                  skipping = 0;
                  sort_words();
                  sending = 1;
               end
               rd_word = 0;
               rd_char = 0;
               r.word_count = nwords[8:0];
            end
            FUNC_PULL: begin
               if (!sending || rd_word >= nwords) begin
                  r.out_empty = 1;
               end else begin
                  w = order[rd_word];
                  if (rd_char < lens[w]) begin
                     r.out_byte = chars[w][rd_char];
                     rd_char++;
                  end else begin
                     r.out_byte = CHAR_NEWLINE;
                     rd_char = 0;
                     rd_word++;
                     r.last_byte = (rd_word >= nwords);
                  end
               end
            end
            default: return;
         endcase
         expected_rsp.push_back(r);
      endfunction

      function bit is_sep(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_TAB;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_result(sorted_rsp_t got);
         sorted_rsp_t exp;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected result byte %0d", got.out_byte));
            return;
         end
         exp = expected_rsp.pop_front();
         if (got.out_byte !== exp.out_byte)
            report($sformatf("out_byte %0d, want %0d", got.out_byte, exp.out_byte));
         if (got.word_count !== exp.word_count)
            report($sformatf("word_count %0d, want %0d", got.word_count, exp.word_count));
         if (got.last_byte !== exp.last_byte)
            report($sformatf("last_byte %0b, want %0b", got.last_byte, exp.last_byte));
         if (got.out_empty !== exp.out_empty)
            report($sformatf("out_empty %0b, want %0b", got.out_empty, exp.out_empty));
      endtask
   endclass

   logic clock;
   logic reset;
   wts_req_if req_ch();
   wts_rsp_if rsp_ch();

   word_tokenize_and_sort_core #(.NUM_WORDS(NUM_WORDS), .WORD_LEN(WORD_LEN)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   word_sort_scoreboard sorted_words = new();
   bit steady;
   int rsp_stall = 0;
   int idle_cycles;
   int words_sent;
   int items_sent;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Stall the result side at random, with quiet stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!steady && $urandom_range(0, 99) < 25) rsp_stall = pick_gap();
      end
   end

   // Sample accepted items and results, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sorted_words.note_item(req_ch.func, req_ch.text_byte);
         if (rsp_ch.valid && rsp_ch.ready)
            sorted_words.check_result('{rsp_ch.out_byte, rsp_ch.word_count,
                                        rsp_ch.last_byte, rsp_ch.out_empty});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("tb_word_tokenize_and_sort_core failed");
               $finish;
            end
         end
      end
   end

   task send_item(func_type f, logic [7:0] c);
      int gap;
      gap = steady ? 0 : pick_gap();
      items_sent++;
      if (items_sent % 150 == 0) steady = ~steady;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.text_byte <= c;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [7:0] word_char();
      logic [7:0] c;
      if ($urandom_range(0, 99) < 75) begin
         c = 8'd97 + 8'($urandom_range(0, 3));
         if ($urandom_range(0, 1)) c -= 8'd32;
         return c;
      end
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_TAB);
      return c;
   endfunction

   function automatic logic [7:0] separator();
      case ($urandom_range(0, 2))
         0: return CHAR_SPACE;
         1: return CHAR_NEWLINE;
         default: return CHAR_TAB;
      endcase
   endfunction

   // Send a word of the given length, optionally closed by a separator
   task send_word(int len, bit closed);
      for (int i = 0; i < len; i++) send_item(FUNC_TEXT, word_char());
      if (closed) begin
         send_item(FUNC_TEXT, separator());
         if ($urandom_range(0, 19) == 0) send_item(FUNC_TEXT, separator());
         words_sent++;
      end
   endtask

   task drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sorted_words.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task pull_bytes(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0) send_item(FUNC_NONE, 8'($urandom));
         send_item(FUNC_PULL, 8'($urandom));
      end
   endtask

   initial begin
      int len;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.func      = FUNC_NONE;
      req_ch.text_byte = 8'd0;
      steady           = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: pull while loading, unused code, odd bytes, ties, prefixes, long word
      send_item(FUNC_PULL, 8'd0);
      send_item(FUNC_NONE, 8'hFF);
      send_item(FUNC_TEXT, 8'd0);
      send_item(FUNC_TEXT, CHAR_TAB);
      send_item(FUNC_TEXT, 8'd255);
      send_item(FUNC_TEXT, CHAR_NEWLINE);
      send_item(FUNC_TEXT, "A");
      send_item(FUNC_TEXT, "b");
      send_item(FUNC_TEXT, CHAR_SPACE);
      send_item(FUNC_TEXT, CHAR_SPACE);
      send_item(FUNC_TEXT, "a");
      send_item(FUNC_TEXT, "B");
      send_item(FUNC_TEXT, CHAR_SPACE);
      send_item(FUNC_TEXT, "a");
      send_item(FUNC_TEXT, CHAR_SPACE);
      words_sent = 5;
      send_word(17, 1);
      send_word(15, 1);

      // Random words up to one short of the store limit, mostly single characters
      while (words_sent < NUM_WORDS - 1) begin
         case ($urandom_range(0, 49))
            0: len = $urandom_range(16, 22);
            1: len = $urandom_range(6, 15);
            default: len = 1;
         endcase
         if ($urandom_range(0, 29) == 0) send_item(FUNC_NONE, 8'($urandom));
         if ($urandom_range(0, 49) == 0) send_item(FUNC_PULL, 8'($urandom));
         send_word(len, 1);
      end

      // Either a final word with no separator, or overflow the store
      if ($urandom_range(0, 1)) begin
         send_word($urandom_range(1, 20), 0);
      end else begin
         send_word(20, 0);
         for (int i = 0; i < 10; i++) send_item(FUNC_TEXT, 8'($urandom));
      end

      // Sort, then read out everything and run past the end
      send_item(FUNC_END, 8'($urandom));
      drain();
      pull_bytes(sorted_words.output_bytes() + 3);
      for (int i = 0; i < 10; i++) send_item(FUNC_TEXT, 8'($urandom));
      send_item(FUNC_END, 8'd0);
      pull_bytes($urandom_range(0, 40));
      send_item(FUNC_END, 8'd0);
      pull_bytes($urandom_range(0, 40));

      drain();
      repeat (8) @(posedge clock);
      if (sorted_words.errors == 0)
         $display("tb_word_tokenize_and_sort_core passed");
      else
         $display("tb_word_tokenize_and_sort_core failed");
      $finish;
   end

endmodule
